/* design/evt3_pkg.sv */
package evt3_pkg;

    localparam int VECTOR_WIDE = 12;
    localparam int VECTOR_NARROW = 8;
    localparam int IDX_W = $clog2(VECTOR_WIDE);

    localparam logic [47:0] WRAP_LIMIT = 48'hFFF000 - (48'd10 << 12);

    typedef enum logic [3:0] {
        KIND_ROW       = 4'h0,
        KIND_ROW_OTHER = 4'h1,
        KIND_X_POS     = 4'h2,
        KIND_X_BASE    = 4'h3,
        KIND_VECT12    = 4'h4,
        KIND_VECT8     = 4'h5,
        KIND_TIME_LOW  = 4'h6,
        KIND_TIME_HIGH = 4'h8
    } word_kind_t;

    typedef struct packed {
        logic [11:0]            x_base;
        logic [VECTOR_WIDE-1:0] mask;
        logic [10:0]            row;
        logic [47:0]            stamp;
        logic                   pol;
    } event_job_t;

endpackage

/* design/evt3_emit.sv */
module evt3_emit
    import evt3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_push,
    input  event_job_t  job_in,
    output logic        job_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // event_x[11:0], event_y[22:12], event_time[70:23], event_polarity[71]
    output logic        m_tlast
);

    logic                   job_valid_reg;
    event_job_t             job_reg;
    logic                   m_tvalid_reg;
    logic [71:0]            m_tdata_reg;
    logic                   m_tlast_reg;

    logic [IDX_W-1:0]       idx;
    logic [VECTOR_WIDE-1:0] rest;
    logic [11:0]            col;
    logic                   out_load;
    logic                   job_done;

    // lowest set bit goes first
    always_comb begin
        idx = '0;
        for (int i = VECTOR_WIDE - 1; i >= 0; i--) begin
            if (job_reg.mask[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign rest     = job_reg.mask & (job_reg.mask - 1'b1);
    assign col      = job_reg.x_base + 12'(idx);
    assign out_load = job_valid_reg && (!m_tvalid_reg || m_tready);
    assign job_done = out_load && (rest == '0);
    assign job_free = !job_valid_reg || job_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (job_push) begin
                job_valid_reg <= 1'b1;
            end else if (job_done) begin
                job_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_push) begin
            job_reg <= job_in;
        end else if (out_load) begin
            job_reg.mask <= rest;
        end
        if (out_load) begin
            m_tdata_reg <= {job_reg.pol, job_reg.stamp, job_reg.row, col};
            m_tlast_reg <= (rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_job_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (job_reg.mask != '0))
        else $error("pending job has no events left");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> job_free)
        else $error("job pushed over a busy job");

    a_done_sets_last: assert property (@(posedge aclk) disable iff (!aresetn)
        job_done |=> (m_tvalid_reg && m_tlast_reg))
        else $error("final event of a job not marked last");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !job_done) |=> (m_tvalid_reg && !m_tlast_reg && job_valid_reg))
        else $error("mid-job event mishandled");

endmodule

/* design/evt3_event_stream_decoder.sv */
// An accepted word is registered in word_reg, then in the emitter's job_reg, then on m_tdata.
// Throughput: one word per cycle unless a word with events waits for the emitter; a word
// that yields k events occupies the event emitter until its k-th event is loaded (one event
// per cycle unless m_tready stalls), and the next word with events holds s_tready low meanwhile.
// Reset: synchronous, active low aresetn clears all decoder state and empties the pipeline.
module evt3_event_stream_decoder
    import evt3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // raw_word[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // event_x[11:0], event_y[22:12], event_time[70:23], event_polarity[71]
    output logic        m_tlast    // last_of_word
);

    logic        word_valid_reg;
    logic [15:0] word_reg;

    logic        base_seen_reg,    base_seen_next;
    logic [47:0] time_base_reg,    time_base_next;
    logic [23:0] wrap_count_reg,   wrap_count_next;
    logic [47:0] now_time_reg,     now_time_next;
    logic [11:0] column_base_reg,  column_base_next;
    logic [10:0] row_now_reg,      row_now_next;
    logic        polarity_now_reg, polarity_now_next;
    logic        change_mode_reg,  change_mode_next;

    logic [3:0]  kind;
    logic [11:0] pay;
    logic [47:0] cand;
    logic [47:0] diff;
    logic        has_events;
    event_job_t  job;
    logic        job_free;
    logic        word_go;

    assign kind = word_reg[15:12];
    assign pay  = word_reg[11:0];
    assign cand = {wrap_count_reg, pay, 12'd0};
    assign diff = time_base_reg - cand;

    always_comb begin
        base_seen_next    = base_seen_reg;
        time_base_next    = time_base_reg;
        wrap_count_next   = wrap_count_reg;
        now_time_next     = now_time_reg;
        column_base_next  = column_base_reg;
        row_now_next      = row_now_reg;
        polarity_now_next = polarity_now_reg;
        change_mode_next  = change_mode_reg;
        has_events        = 1'b0;
        job.x_base        = column_base_reg;
        job.mask          = pay;
        job.row           = row_now_reg;
        job.stamp         = now_time_reg;
        job.pol           = polarity_now_reg;

        if (!base_seen_reg) begin
            if (kind == KIND_TIME_HIGH) begin
                time_base_next = {24'd0, pay, 12'd0};
                base_seen_next = 1'b1;
            end
        end else begin
            case (kind)
                KIND_TIME_HIGH: begin
                    if ((time_base_reg > cand) && (diff >= WRAP_LIMIT)) begin
                        time_base_next  = {wrap_count_reg + 24'd1, pay, 12'd0};
                        wrap_count_next = wrap_count_reg + 24'd1;
                    end else begin
                        time_base_next = cand;
                    end
                    now_time_next = time_base_next;
                end
                KIND_TIME_LOW: begin
                    now_time_next = time_base_reg + {36'd0, pay};
                end
                KIND_ROW: begin
                    change_mode_next = 1'b1;
                    row_now_next     = pay[10:0];
                end
                KIND_ROW_OTHER: begin
                    change_mode_next = 1'b0;
                end
                KIND_X_BASE: begin
                    polarity_now_next = pay[11];
                    column_base_next  = {1'b0, pay[10:0]};
                end
                KIND_X_POS: begin
                    column_base_next = {1'b0, pay[10:0]};
                    job.x_base       = {1'b0, pay[10:0]};
                    job.mask         = VECTOR_WIDE'(1);
                    job.pol          = pay[11];
                    has_events       = change_mode_reg;
                end
                KIND_VECT12: begin
                    column_base_next = column_base_reg + 12'(VECTOR_WIDE);
                    has_events       = change_mode_reg && (pay != '0);
                end
                KIND_VECT8: begin
                    column_base_next = column_base_reg + 12'(VECTOR_NARROW);
                    job.mask         = {{(VECTOR_WIDE - VECTOR_NARROW){1'b0}},
                                        pay[VECTOR_NARROW-1:0]};
                    has_events       = change_mode_reg && (pay[VECTOR_NARROW-1:0] != '0);
                end
                default: begin
                end
            endcase
        end
    end

    assign word_go  = word_valid_reg && (job_free || !has_events);
    assign s_tready = !word_valid_reg || word_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_valid_reg   <= 1'b0;
            base_seen_reg    <= 1'b0;
            time_base_reg    <= '0;
            wrap_count_reg   <= '0;
            now_time_reg     <= '0;
            column_base_reg  <= '0;
            row_now_reg      <= '0;
            polarity_now_reg <= 1'b0;
            change_mode_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                word_valid_reg <= s_tvalid;
            end
            if (word_go) begin
                base_seen_reg    <= base_seen_next;
                time_base_reg    <= time_base_next;
                wrap_count_reg   <= wrap_count_next;
                now_time_reg     <= now_time_next;
                column_base_reg  <= column_base_next;
                row_now_reg      <= row_now_next;
                polarity_now_reg <= polarity_now_next;
                change_mode_reg  <= change_mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            word_reg <= s_tdata;
        end
    end

    evt3_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_push (word_go && has_events),
        .job_in   (job),
        .job_free (job_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
